[src/assert_macros.svh]
// assertion macros shared by the face normal datapath
// no dependencies; included by the modules that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TFN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define TFN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/tfn_pkg.sv]
// types and constants of the triangle face normal segment unit
// no dependencies; used by every other file of the block except assert_macros.svh
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< SAT_W - 1) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NORM      = 1'b1;
  localparam logic [CFG_W-1:0] NORMAL_LENGTH_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MIN_NORM_RST      = 31'd1;

  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 31;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int DVD_W      = 62;
  localparam int QUO_W      = 31;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } tri_t;

  typedef struct packed {
    coord_t base_x;
    coord_t base_y;
    coord_t base_z;
    coord_t tip_x;
    coord_t tip_y;
    coord_t tip_z;
    logic   degenerate;
  } seg_t;

  // per-item side data that rides along the root and divide pipelines
  typedef struct packed {
    logic [2:0][31:0] base;
    logic [2:0][31:0] dsat;
    logic             degen;
    logic [2:0]       rneg;
  } fin_t;

  typedef logic [2:0][DVD_W-1:0] dvd3_t;
  typedef logic [2:0][QUO_W-1:0] quo3_t;

endpackage

`default_nettype wire

[src/tfn_stream_if.sv]
// valid/ready stream interfaces for triangle beats and segment beats
// depends on tfn_pkg
`default_nettype none

interface tfn_tri_if;
  logic          valid;
  logic          ready;
  tfn_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfn_seg_if;
  logic          valid;
  logic          ready;
  tfn_pkg::seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/tfn_isqrt.sv]
// pipelined integer square root, one root bit per stage
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfn_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tfn_pkg::RAD_W-1:0]     rad_i,
  input  wire tfn_pkg::fin_t                 fin_i,
  input  wire tfn_pkg::dvd3_t                dvd_i,
  output logic                               valid_o,
  output logic [tfn_pkg::ROOT_W-1:0]         root_o,
  output tfn_pkg::fin_t                      fin_o,
  output tfn_pkg::dvd3_t                     dvd_o
);

  localparam int NS = tfn_pkg::SQ_STAGES;

  logic                           vld_q  [NS];
  logic [tfn_pkg::ROOT_W+2:0]     rem_q  [NS];
  logic [tfn_pkg::ROOT_W-1:0]     root_q [NS];
  logic [tfn_pkg::RAD_W-1:0]      rad_q  [NS];
  tfn_pkg::fin_t                  fin_q  [NS];
  tfn_pkg::dvd3_t                 dvd_q  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int I = NS - 1 - j;
    logic                       vld_in;
    logic [tfn_pkg::ROOT_W+2:0] rem_in;
    logic [tfn_pkg::ROOT_W-1:0] root_in;
    logic [tfn_pkg::RAD_W-1:0]  rad_in;
    tfn_pkg::fin_t              fin_in;
    tfn_pkg::dvd3_t             dvd_in;
    logic [tfn_pkg::ROOT_W+2:0] rs;
    logic [tfn_pkg::ROOT_W+2:0] trial;
    logic                       ge;

    if (j == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign fin_in  = fin_i;
      assign dvd_in  = dvd_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign fin_in  = fin_q[j-1];
      assign dvd_in  = dvd_q[j-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign rs    = {rem_in[tfn_pkg::ROOT_W:0], rad_in[2*I+1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (rs >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (rs - trial) : rs;
        root_q[j] <= {root_in[tfn_pkg::ROOT_W-2:0], ge};
        rad_q[j]  <= rad_in;
        fin_q[j]  <= fin_in;
        dvd_q[j]  <= dvd_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign fin_o   = fin_q[NS-1];
  assign dvd_o   = dvd_q[NS-1];

  // remainder never exceeds twice the root
  `TFN_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, vld_q[NS-1],
    rem_q[NS-1] <= {2'b00, root_q[NS-1], 1'b0})

endmodule

`default_nettype wire

[src/tfn_div.sv]
// three-lane pipelined restoring divider, one quotient bit per stage
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfn_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [tfn_pkg::ROOT_W-1:0] dvs_i,
  input  wire tfn_pkg::dvd3_t            dvd_i,
  input  wire tfn_pkg::fin_t             fin_i,
  output logic                           valid_o,
  output tfn_pkg::quo3_t                 quo_o,
  output tfn_pkg::fin_t                  fin_o
);

  localparam int NS = tfn_pkg::DIV_STAGES;
  localparam int RW = tfn_pkg::ROOT_W;

  logic                    vld_q [NS];
  logic [2:0][RW-1:0]      rem_q [NS];
  tfn_pkg::quo3_t          quo_q [NS];
  logic [RW-1:0]           dvs_q [NS];
  tfn_pkg::dvd3_t          dvd_q [NS];
  tfn_pkg::fin_t           fin_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int I = NS - 1 - j;
    logic               vld_in;
    logic [2:0][RW-1:0] rem_in;
    tfn_pkg::quo3_t     quo_in;
    logic [RW-1:0]      dvs_in;
    tfn_pkg::dvd3_t     dvd_in;
    tfn_pkg::fin_t      fin_in;
    logic [2:0][RW-1:0] rem_d;
    tfn_pkg::quo3_t     quo_d;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign dvs_in = dvs_i;
      assign dvd_in = dvd_i;
      assign fin_in = fin_i;
      assign quo_in = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = RW'(dvd_i[l][tfn_pkg::DVD_W-1:tfn_pkg::QUO_W]);
      end
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dvs_in = dvs_q[j-1];
      assign dvd_in = dvd_q[j-1];
      assign fin_in = fin_q[j-1];
    end

    always_comb begin
      logic [RW:0] rs;
      rem_d = '0;
      quo_d = '0;
      rs    = '0;
      for (int l = 0; l < 3; l++) begin
        rs = {rem_in[l], dvd_in[l][I]};
        if (rs >= {1'b0, dvs_in}) begin
          rem_d[l] = RW'(rs - {1'b0, dvs_in});
          quo_d[l] = {quo_in[l][tfn_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = rs[RW-1:0];
          quo_d[l] = {quo_in[l][tfn_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        dvs_q[j] <= dvs_in;
        dvd_q[j] <= dvd_in;
        fin_q[j] <= fin_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign fin_o   = fin_q[NS-1];

  // final partial remainders stay below the divisor
  `TFN_ASSERT_IMP(a_rem_lt_dvs, clk_i, rst_ni, vld_q[NS-1],
    (rem_q[NS-1][0] < dvs_q[NS-1]) && (rem_q[NS-1][1] < dvs_q[NS-1]) &&
    (rem_q[NS-1][2] < dvs_q[NS-1]))

endmodule

`default_nettype wire

[src/triangle_face_normal_segment_unit.sv]
// top level of the triangle face normal segment unit
// depends on tfn_pkg, tfn_stream_if, tfn_isqrt, tfn_div, assert_macros.svh
//
//   port        dir  beat / use
//   tri_in      in   triangle: nine signed Q16.16 vertex coordinates
//   seg_out     out  centroid, tip point, degenerate flag
//   cfg_*_i     in   register write: normal_length (0), min_norm (1)
//
// one beat per cycle unless stalled; accept to result passes 10 front stages,
// 32 root stages, 31 divide stages and one output register
// the whole pipeline advances when the output register is empty or taken
// reset clears valid bits and loads the register reset values
`default_nettype none
`include "assert_macros.svh"

module triangle_face_normal_segment_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tfn_tri_if.sink                             tri_in,
  tfn_seg_if.source                           seg_out,
  input  wire logic                           cfg_we_i,
  input  wire logic [tfn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tfn_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam logic [32:0] DIV3_MUL = 33'd5726623062;

  function automatic tfn_pkg::coord_t sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > tfn_pkg::SAT_HI) r = tfn_pkg::SAT_HI;
    else if (v < tfn_pkg::SAT_LO) r = tfn_pkg::SAT_LO;
    return r[31:0];
  endfunction

  function automatic logic [5:0] bitlen(input logic [49:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  // config registers
  logic [tfn_pkg::CFG_W-1:0] nlen_q, mnorm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlen_q  <= tfn_pkg::NORMAL_LENGTH_RST;
      mnorm_q <= tfn_pkg::MIN_NORM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfn_pkg::REG_NORMAL_LENGTH: nlen_q  <= cfg_wdata_i;
        tfn_pkg::REG_MIN_NORM:      mnorm_q <= cfg_wdata_i;
        default:                    nlen_q  <= nlen_q;
      endcase
    end
  end

  logic adv;
  logic out_vld_q;
  tfn_pkg::seg_t out_q;

  assign adv          = !out_vld_q || seg_out.ready;
  assign tri_in.ready = adv;

  logic [10:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[9:1], tri_in.valid};
    end
  end

  tfn_pkg::coord_t va [3], vb [3], vc [3];
  assign va[0] = tri_in.data.ax;
  assign va[1] = tri_in.data.ay;
  assign va[2] = tri_in.data.az;
  assign vb[0] = tri_in.data.bx;
  assign vb[1] = tri_in.data.by_coord;
  assign vb[2] = tri_in.data.bz;
  assign vc[0] = tri_in.data.cx;
  assign vc[1] = tri_in.data.cy;
  assign vc[2] = tri_in.data.cz;

  logic signed [33:0] sum1_q [3];
  logic signed [32:0] e1_q [3], e2_q [3];
  logic               cneg2_q [3];
  logic [32:0]        cmag2_q [3];
  logic signed [65:0] prod2_q [6];
  logic signed [50:0] n3_q [3];
  logic               cneg3_q [3];
  logic [65:0]        cprod3_q [3];
  tfn_pkg::coord_t    base4_q [3], dsat4_q [3];
  logic [49:0]        nm4_q [3];
  logic signed [50:0] n4_q [3];
  tfn_pkg::coord_t    base5_q [3], dsat5_q [3];
  logic [49:0]        m5_q;
  logic [49:0]        hh5_q [3], hl5_q [3], ll5_q [3];
  logic [61:0]        mn2_5_q;
  logic signed [50:0] n5_q [3];
  tfn_pkg::coord_t    base6_q [3], dsat6_q [3];
  logic [99:0]        sq6_q [3];
  logic [5:0]         b6_q;
  logic [61:0]        mn2_6_q;
  logic signed [50:0] n6_q [3];
  tfn_pkg::coord_t    base7_q [3], dsat7_q [3];
  logic               degen7_q;
  logic signed [31:0] r7_q [3];
  tfn_pkg::coord_t    base8_q [3], dsat8_q [3];
  logic               degen8_q;
  logic               rneg8_q [3];
  logic [31:0]        rm8_q [3];
  tfn_pkg::coord_t    base9_q [3], dsat9_q [3];
  logic               degen9_q;
  logic               rneg9_q [3];
  logic [63:0]        sqr9_q [3];
  logic [tfn_pkg::DVD_W-1:0] dvd9_q [3];
  logic [63:0]        s10_q;
  tfn_pkg::fin_t      fin10_q;
  tfn_pkg::dvd3_t     dvd10_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // front: sums and edges
        sum1_q[k] <= 34'(va[k]) + 34'(vb[k]) + 34'(vc[k]);
        e1_q[k]   <= 33'(vb[k]) - 33'(va[k]);
        e2_q[k]   <= 33'(vc[k]) - 33'(va[k]);
        // centroid magnitude, then divide by three via reciprocal
        cneg2_q[k]  <= sum1_q[k][33];
        cmag2_q[k]  <= sum1_q[k][33] ? 33'(-sum1_q[k]) : 33'(sum1_q[k]);
        cneg3_q[k]  <= cneg2_q[k];
        cprod3_q[k] <= 66'(cmag2_q[k]) * 66'(DIV3_MUL);
        base4_q[k]  <= cneg3_q[k] ? sat(-64'(cprod3_q[k][65:34]))
                                  : sat(64'(cprod3_q[k][65:34]));
        // cross magnitudes
        nm4_q[k]   <= n3_q[k][50] ? 50'(-n3_q[k]) : 50'(n3_q[k]);
        n4_q[k]    <= n3_q[k];
        dsat4_q[k] <= sat(64'(n3_q[k]));
        // squared length partial products
        hh5_q[k]   <= 50'(nm4_q[k][49:25]) * 50'(nm4_q[k][49:25]);
        hl5_q[k]   <= 50'(nm4_q[k][49:25]) * 50'(nm4_q[k][24:0]);
        ll5_q[k]   <= 50'(nm4_q[k][24:0]) * 50'(nm4_q[k][24:0]);
        n5_q[k]    <= n4_q[k];
        base5_q[k] <= base4_q[k];
        dsat5_q[k] <= dsat4_q[k];
        sq6_q[k]   <= (100'(hh5_q[k]) << 50) + (100'(hl5_q[k]) << 26) + 100'(ll5_q[k]);
        n6_q[k]    <= n5_q[k];
        base6_q[k] <= base5_q[k];
        dsat6_q[k] <= dsat5_q[k];
        // common shift so the largest component has 31 significant bits
        if (b6_q > 6'd31) r7_q[k] <= 32'(n6_q[k] >>> (b6_q - 6'd31));
        else              r7_q[k] <= 32'(n6_q[k] <<< (6'd31 - b6_q));
        base7_q[k] <= base6_q[k];
        dsat7_q[k] <= dsat6_q[k];
        rneg8_q[k] <= r7_q[k][31];
        rm8_q[k]   <= r7_q[k][31] ? 32'(-33'(r7_q[k])) : 32'(r7_q[k]);
        base8_q[k] <= base7_q[k];
        dsat8_q[k] <= dsat7_q[k];
        sqr9_q[k]  <= 64'(rm8_q[k]) * 64'(rm8_q[k]);
        dvd9_q[k]  <= tfn_pkg::DVD_W'(rm8_q[k]) * tfn_pkg::DVD_W'(nlen_q);
        rneg9_q[k] <= rneg8_q[k];
        base9_q[k] <= base8_q[k];
        dsat9_q[k] <= dsat8_q[k];
        fin10_q.base[k] <= base9_q[k];
        fin10_q.dsat[k] <= dsat9_q[k];
        fin10_q.rneg[k] <= rneg9_q[k];
        dvd10_q[k]      <= dvd9_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        n3_q[k] <= 51'((67'(prod2_q[2*k]) - 67'(prod2_q[2*k+1])) >>> 16);
      end
      prod2_q[0] <= e1_q[1] * e2_q[2];
      prod2_q[1] <= e1_q[2] * e2_q[1];
      prod2_q[2] <= e1_q[2] * e2_q[0];
      prod2_q[3] <= e1_q[0] * e2_q[2];
      prod2_q[4] <= e1_q[0] * e2_q[1];
      prod2_q[5] <= e1_q[1] * e2_q[0];
      m5_q <= (nm4_q[0] >= nm4_q[1])
              ? ((nm4_q[0] >= nm4_q[2]) ? nm4_q[0] : nm4_q[2])
              : ((nm4_q[1] >= nm4_q[2]) ? nm4_q[1] : nm4_q[2]);
      mn2_5_q  <= 62'(mnorm_q) * 62'(mnorm_q);
      b6_q     <= bitlen(m5_q);
      mn2_6_q  <= mn2_5_q;
      degen7_q <= (102'(sq6_q[0]) + 102'(sq6_q[1]) + 102'(sq6_q[2])) <= 102'(mn2_6_q);
      degen8_q <= degen7_q;
      degen9_q <= degen8_q;
      s10_q    <= sqr9_q[0] + sqr9_q[1] + sqr9_q[2];
      fin10_q.degen <= degen9_q;
    end
  end

  logic                          sq_vld;
  logic [tfn_pkg::ROOT_W-1:0]    sq_root;
  tfn_pkg::fin_t                 sq_fin;
  tfn_pkg::dvd3_t                sq_dvd;
  logic [tfn_pkg::ROOT_W-1:0]    dvs;

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[10]),
    .rad_i   (s10_q),
    .fin_i   (fin10_q),
    .dvd_i   (dvd10_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .fin_o   (sq_fin),
    .dvd_o   (sq_dvd)
  );

  assign dvs = (sq_root == '0) ? tfn_pkg::ROOT_W'(1) : sq_root;

  logic           dv_vld;
  tfn_pkg::quo3_t dv_quo;
  tfn_pkg::fin_t  dv_fin;

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .dvs_i   (dvs),
    .dvd_i   (sq_dvd),
    .fin_i   (sq_fin),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .fin_o   (dv_fin)
  );

  tfn_pkg::coord_t tip [3];

  always_comb begin
    logic signed [33:0] off;
    off = '0;
    for (int k = 0; k < 3; k++) begin
      if (dv_fin.degen)      off = 34'($signed(dv_fin.dsat[k]));
      else if (dv_fin.rneg[k]) off = -34'(dv_quo[k]);
      else                   off = 34'(dv_quo[k]);
      tip[k] = sat(64'($signed(dv_fin.base[k])) + 64'(off));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.base_x     <= dv_fin.base[0];
      out_q.base_y     <= dv_fin.base[1];
      out_q.base_z     <= dv_fin.base[2];
      out_q.tip_x      <= tip[0];
      out_q.tip_y      <= tip[1];
      out_q.tip_z      <= tip[2];
      out_q.degenerate <= dv_fin.degen;
    end
  end

  assign seg_out.valid = out_vld_q;
  assign seg_out.data  = out_q;

  // a normalized item always has a root of at least 2^30
  `TFN_ASSERT_IMP(a_root_floor, clk_i, rst_ni, sq_vld && !sq_fin.degen,
    sq_root >= 32'h4000_0000)

endmodule

`default_nettype wire

[dv/tb.sv]
// testbench for triangle_face_normal_segment_unit: drives triangle beats, predicts each segment
// and compares every field; depends on tfn_pkg, tfn_stream_if and the unit itself
`timescale 1ns / 100ps

module tb;
  import tfn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          LATENCY     = 74;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  tfn_tri_if tri_if ();
  tfn_seg_if seg_if ();

  triangle_face_normal_segment_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_in      (tri_if.sink),
    .seg_out     (seg_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [CFG_W-1:0] seg_length;
  logic [CFG_W-1:0] flat_limit;
  seg_t             expected_segments[$];
  int unsigned      mismatches;
  int unsigned      cycle_count;
  bit               hold_off_req;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = longint'(SAT_HI);
    lo = longint'(SAT_LO);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint cross_term(longint p, longint q, longint s, longint t);
    logic signed [127:0] pw;
    logic signed [127:0] qw;
    logic signed [127:0] sw;
    logic signed [127:0] tw;
    logic signed [127:0] d;
    pw = p;
    qw = q;
    sw = s;
    tw = t;
    d = pw * qw - sw * tw;
    d = d >>> 16;
    return longint'(d[63:0]);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic seg_t predict_segment(tri_t t);
    longint v[9];
    longint base[3];
    longint n[3];
    longint off[3];
    longint r[3];
    longint e1[3];
    longint e2[3];
    logic signed [127:0] nw;
    logic [127:0] norm2;
    logic [127:0] thr2;
    longint unsigned mx;
    longint unsigned rs;
    longint unsigned q;
    int blen;
    bit degen;
    seg_t o;
    v[0] = t.ax; v[1] = t.ay; v[2] = t.az;
    v[3] = t.bx; v[4] = t.by_coord; v[5] = t.bz;
    v[6] = t.cx; v[7] = t.cy; v[8] = t.cz;
    for (int i = 0; i < 3; i++) begin
      base[i] = clamp_coord((v[i] + v[3+i] + v[6+i]) / 3);
      e1[i] = v[3+i] - v[i];
      e2[i] = v[6+i] - v[i];
    end
    n[0] = cross_term(e1[1], e2[2], e1[2], e2[1]);
    n[1] = cross_term(e1[2], e2[0], e1[0], e2[2]);
    n[2] = cross_term(e1[0], e2[1], e1[1], e2[0]);
    norm2 = 0;
    for (int i = 0; i < 3; i++) begin
      nw = n[i];
      norm2 = norm2 + 128'(nw * nw);
    end
    thr2 = 128'(flat_limit) * 128'(flat_limit);
    degen = (norm2 <= thr2);
    if (degen) begin
      for (int i = 0; i < 3; i++) off[i] = clamp_coord(n[i]);
    end else begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        if (longint'(n[i] < 0 ? -n[i] : n[i]) > longint'(mx)) mx = n[i] < 0 ? -n[i] : n[i];
      end
      blen = 0;
      while (blen < 64 && (mx >> blen) != 0) blen++;
      rs = 0;
      for (int i = 0; i < 3; i++) begin
        if (blen > 31) r[i] = n[i] >>> (blen - 31);
        else r[i] = n[i] * (longint'(1) << (31 - blen));
        rs = rs + longint'(r[i] * r[i]);
      end
      q = floor_sqrt(rs);
      if (q == 0) q = 1;
      for (int i = 0; i < 3; i++) off[i] = (r[i] * longint'(seg_length)) / longint'(q);
    end
    o.base_x = base[0][31:0];
    o.base_y = base[1][31:0];
    o.base_z = base[2][31:0];
    o.tip_x = 32'(clamp_coord(base[0] + off[0]));
    o.tip_y = 32'(clamp_coord(base[1] + off[1]));
    o.tip_z = 32'(clamp_coord(base[2] + off[2]));
    o.degenerate = degen;
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatches++;
  endtask

  // result side: compare each accepted beat with the oldest prediction
  always @(posedge clk_i) begin
    seg_t got;
    seg_t want;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      got = seg_if.data;
      if (expected_segments.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_segments.pop_front();
        if (got.base_x !== want.base_x) report_mismatch("base_x", got.base_x, want.base_x);
        if (got.base_y !== want.base_y) report_mismatch("base_y", got.base_y, want.base_y);
        if (got.base_z !== want.base_z) report_mismatch("base_z", got.base_z, want.base_z);
        if (got.tip_x !== want.tip_x) report_mismatch("tip_x", got.tip_x, want.tip_x);
        if (got.tip_y !== want.tip_y) report_mismatch("tip_y", got.tip_y, want.tip_y);
        if (got.tip_z !== want.tip_z) report_mismatch("tip_z", got.tip_z, want.tip_z);
        if (got.degenerate !== want.degenerate)
          report_mismatch("degenerate", got.degenerate, want.degenerate);
      end
    end
  end

  // receiver stalls, plus a long hold-off on request
  initial begin
    int run;
    seg_if.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_off_req) begin
        seg_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if ($urandom_range(0, 9) < 6) begin
        seg_if.ready <= 1'b1;
        run = $urandom_range(1, 40);
        repeat (run) @(posedge clk_i);
      end else begin
        seg_if.ready <= 1'b0;
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  task automatic send_triangle(tri_t t, bit no_gap = 0);
    int gap;
    tri_if.valid <= 1'b1;
    tri_if.data <= t;
    do @(posedge clk_i); while (!tri_if.ready);
    expected_segments.push_back(predict_segment(t));
    gap = 0;
    if (!no_gap) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
        5: gap = $urandom_range(10, 60);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      tri_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_sending();
    tri_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    finish_sending();
    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NORMAL_LENGTH) seg_length = val;
    else flat_limit = val;
  endtask

  function automatic tri_t make_tri(coord_t a0, coord_t a1, coord_t a2, coord_t b0,
                                    coord_t b1, coord_t b2, coord_t c0, coord_t c1, coord_t c2);
    tri_t t;
    t.ax = a0; t.ay = a1; t.az = a2;
    t.bx = b0; t.by_coord = b1; t.bz = b2;
    t.cx = c0; t.cy = c1; t.cz = c2;
    return t;
  endfunction

  function automatic coord_t near(coord_t c, int sh);
    longint d;
    d = longint'($signed($urandom())) >>> (31 - sh);
    return 32'(clamp_coord(longint'(c) + d));
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    coord_t c[3];
    int sh;
    int k;
    for (int i = 0; i < 3; i++) c[i] = $urandom();
    sh = $urandom_range(0, 24);
    case ($urandom_range(0, 9))
      0, 1: t = make_tri($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom());
      2: begin
        // collinear vertices
        k = $urandom_range(0, 4) - 2;
        t = make_tri(c[0], c[1], c[2], near(c[0], sh), near(c[1], sh), near(c[2], sh), 0, 0, 0);
        t.cx = 32'(clamp_coord(longint'(t.ax) + k * (longint'(t.bx) - t.ax)));
        t.cy = 32'(clamp_coord(longint'(t.ay) + k * (longint'(t.by_coord) - t.ay)));
        t.cz = 32'(clamp_coord(longint'(t.az) + k * (longint'(t.bz) - t.az)));
      end
      3: t = make_tri(c[0], c[1], c[2], near(c[0], 1), near(c[1], 1), near(c[2], 1),
                      near(c[0], 1), near(c[1], 1), near(c[2], 1));
      default: t = make_tri(c[0], c[1], c[2], near(c[0], sh), near(c[1], sh), near(c[2], sh),
                            near(c[0], sh), near(c[1], sh), near(c[2], sh));
    endcase
    return t;
  endfunction

  task automatic test_directed();
    coord_t mx;
    coord_t mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_triangle(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_triangle(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    send_triangle(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
    send_triangle(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    send_triangle(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(make_tri(0, 0, 0, 257, 0, 0, 0, 256, 0));
    send_triangle(make_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    send_triangle(make_tri(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    send_triangle(make_tri(-1, -1, -1, 1, 1, 1, 2, 0, -3));
    send_triangle(make_tri(mx - 10, 5, 5, mx, 5, 5, mx - 10, 6000000, 5));
    drain();
  endtask

  task automatic test_register_settings();
    logic [CFG_W-1:0] lengths[4];
    logic [CFG_W-1:0] limits[4];
    lengths = '{31'd0, 31'd1, 31'h7fffffff, 31'd3 << 20};
    limits = '{31'd0, 31'h7fffffff, 31'd65536, 31'd200};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_NORMAL_LENGTH, lengths[s]);
      write_reg(REG_MIN_NORM, limits[s]);
      // normal of length 65536, exactly at the threshold when min_norm is 65536
      send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
      send_triangle(make_tri(0, 0, 0, 65537, 0, 0, 0, 65536, 0));
      for (int i = 0; i < 60; i++) send_triangle(random_tri());
      drain();
    end
    write_reg(REG_NORMAL_LENGTH, NORMAL_LENGTH_RST);
    write_reg(REG_MIN_NORM, MIN_NORM_RST);
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 190; i++) send_triangle(random_tri());
    // sender pause until everything is back
    drain();
    write_reg(REG_NORMAL_LENGTH, 31'($urandom()));
    write_reg(REG_MIN_NORM, 31'($urandom_range(0, 1 << 20)));
    for (int i = 0; i < 200; i++) send_triangle(random_tri());
    drain();
  endtask

  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    for (int i = 0; i < 200; i++) send_triangle(random_tri(), 1);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    tri_if.valid = 1'b0;
    tri_if.data = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_off_req = 1'b0;
    seg_length = NORMAL_LENGTH_RST;
    flat_limit = MIN_NORM_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_register_settings();
    test_random_stream();
    test_output_hold_off();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tfn_pkg.sv
src/tfn_stream_if.sv
src/tfn_isqrt.sv
src/tfn_div.sv
src/triangle_face_normal_segment_unit.sv
dv/tb.sv
